### rtl/skwh_pkg.sv
// Shared types and constants for the sorted-key weighted histogram.
// Used by skwh_div, skwh_dp, skwh_ctrl and sorted_key_weighted_histogram_top.
// No dependencies.
package skwh_pkg;

    localparam int unsigned KEY_W        = 64;  // key, value and sum width
    localparam int unsigned NBIN_W       = 7;   // bin count / bin counter width
    localparam int unsigned BIN_W        = 6;   // emitted bin index width
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned DEF_MAX_BINS = 64;
    localparam int unsigned DIV_CNT_W    = $clog2(KEY_W);

    localparam logic [NBIN_W-1:0] NUM_BINS_RESET = NBIN_W'(64);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] point_key;
        logic signed [KEY_W-1:0] point_value;
        logic                    final_point;
    } t_point;

    typedef struct packed {
        logic        [BIN_W-1:0] bin_number;
        logic signed [KEY_W-1:0] bin_total;
        logic                    final_bin;
    } t_bin;

    // controller -> datapath
    typedef struct packed {
        logic load_in;     // capture accepted word
        logic div_start;   // launch bin width division
        logic init_batch;  // latch quotient/remainder, first bound
        logic emit;        // push open bin to output, step bound
        logic accum;       // add point value to open bin
        logic finish;      // end of batch
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic started;
        logic div_done;
        logic key_emit;    // point key lies past the open bin
        logic flush_emit;  // bins remain to flush
        logic last;        // held word is the final point
        logic out_free;    // output register can take a word
    } t_stat;

endpackage

### rtl/sorted_key_weighted_histogram_top.sv
// Weighted histogram of key-sorted points: top level.
// Joins skwh_ctrl and skwh_dp; depends on skwh_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_word): one point word of
//   key, value and final flag, keys nondecreasing and signed. Output channel
//   (o_out_valid / i_out_stall / o_out_word): one word per finished bin,
//   in bin order, empty bins included; final_bin marks the last bin.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data): min_key (0),
//   max_key (1), num_bins (2); write only between words.
// Sequence:
//   A point that closes no bin is accepted, then scanned.
//   Each bin it closes adds a scan step that waits for output room; a final
//   point then flushes each remaining bin and ends the batch. The first point
//   of a batch first runs the bin width division, one quotient bit per cycle.
//   A closed bin shows on o_out_valid the cycle after it is scanned.
// Reset: synchronous, active low. Registers return to min_key 0,
//   max_key 0, num_bins 64; no batch open, output empty.
// Back pressure: with i_out_stall high a held bin word stays and the scan
//   waits for room; o_in_stall stays high until the current point is done.
module sorted_key_weighted_histogram_top #(
    parameter int unsigned MAX_BINS = skwh_pkg::DEF_MAX_BINS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [skwh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skwh_pkg::KEY_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  skwh_pkg::t_point                    i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output skwh_pkg::t_bin                      o_out_word
);

    skwh_pkg::t_cmd  cmd;
    skwh_pkg::t_stat stat;

    // sequencing: accept, divide at batch start, scan bins, flush
    skwh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // bounds, sums and the output register
    skwh_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // a taken word keeps the input closed for at least the scan cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // a bin is only pushed when the output register can take it
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("bin emitted into a full output register");

    // a bin is only pushed when a key passed it or a flush is running
    a_emit_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (stat.key_emit || stat.flush_emit))
        else $error("bin emitted without cause");

    // an emitted bin shows on the output the next cycle
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("emitted bin missing at output");

endmodule

### rtl/skwh_div.sv
// Iterative restoring divider: unsigned key-width dividend by bin count.
// One quotient bit per cycle. Depends on skwh_pkg.
module skwh_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [skwh_pkg::KEY_W-1:0]          i_dividend,
    input  logic [skwh_pkg::NBIN_W-1:0]         i_divisor,
    output logic                                o_done,
    output logic [skwh_pkg::KEY_W-1:0]          o_quotient,
    output logic [skwh_pkg::NBIN_W-1:0]         o_remainder
);

    logic                               r_busy;
    logic                               r_done;
    logic [skwh_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [skwh_pkg::KEY_W-1:0]         r_quo;
    logic [skwh_pkg::NBIN_W-1:0]        r_rem;
    logic [skwh_pkg::NBIN_W-1:0]        r_dvs;

    logic [skwh_pkg::NBIN_W:0]          trial;
    logic [skwh_pkg::NBIN_W:0]          diff;
    logic                               ge;
    logic [skwh_pkg::NBIN_W-1:0]        n_rem;

    assign trial = {r_rem, r_quo[skwh_pkg::KEY_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};
    // partial remainder stays below the divisor, so it fits NBIN_W bits
    assign n_rem = ge ? diff[skwh_pkg::NBIN_W-1:0] : trial[skwh_pkg::NBIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[skwh_pkg::KEY_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

### rtl/skwh_dp.sv
// Datapath: config registers, held point, bin bound stepping, running sum,
// output register. Depends on skwh_pkg and skwh_div.
module skwh_dp #(
    parameter int unsigned MAX_BINS = skwh_pkg::DEF_MAX_BINS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [skwh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [skwh_pkg::KEY_W-1:0]          i_cfg_data,
    input  skwh_pkg::t_point                    i_in_word,
    input  logic                                i_out_stall,
    input  skwh_pkg::t_cmd                      i_cmd,
    output skwh_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output skwh_pkg::t_bin                      o_out_word
);

    localparam logic [skwh_pkg::NBIN_W-1:0] MaxN = skwh_pkg::NBIN_W'(MAX_BINS);

    // configuration
    logic signed [skwh_pkg::KEY_W-1:0]  r_min_key;
    logic signed [skwh_pkg::KEY_W-1:0]  r_max_key;
    logic        [skwh_pkg::NBIN_W-1:0] r_num_bins;

    // batch state
    skwh_pkg::t_point                   r_pt;
    logic                               r_started;
    logic        [skwh_pkg::NBIN_W-1:0] r_cur;
    logic signed [skwh_pkg::KEY_W-1:0]  r_sum;
    logic signed [skwh_pkg::KEY_W-1:0]  r_bound;
    logic        [skwh_pkg::KEY_W-1:0]  r_wq;
    logic        [skwh_pkg::NBIN_W-1:0] r_wr;
    logic        [skwh_pkg::NBIN_W-1:0] r_racc;

    logic                               r_out_valid;
    skwh_pkg::t_bin                     r_out;

    logic        [skwh_pkg::NBIN_W-1:0] n;
    logic        [skwh_pkg::KEY_W-1:0]  range;
    logic                               div_done;
    logic        [skwh_pkg::KEY_W-1:0]  div_q;
    logic        [skwh_pkg::NBIN_W-1:0] div_r;
    logic        [skwh_pkg::NBIN_W:0]   cur_inc;
    logic signed [skwh_pkg::KEY_W-1:0]  open_bound;
    logic                               cur_lt_n;
    logic                               key_above_min;
    logic        [skwh_pkg::NBIN_W-1:0] racc_sum;
    logic                               carry;
    logic        [skwh_pkg::NBIN_W-1:0] n_racc;
    logic signed [skwh_pkg::KEY_W-1:0]  n_bound;
    logic                               out_free;

    // bin count clamped to 1..MAX_BINS
    always_comb begin
        if (r_num_bins == '0) begin
            n = skwh_pkg::NBIN_W'(1);
        end else if (r_num_bins > MaxN) begin
            n = MaxN;
        end else begin
            n = r_num_bins;
        end
    end

    assign range = (r_max_key > r_min_key) ? (r_max_key - r_min_key) : '0;

    skwh_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (range),
        .i_divisor   (n),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    assign cur_inc       = {1'b0, r_cur} + 1'b1;
    assign open_bound    = (cur_inc >= {1'b0, n}) ? r_max_key : r_bound;
    assign cur_lt_n      = r_cur < n;
    assign key_above_min = r_pt.point_key > r_min_key;

    // bound step: add quotient, carry one when remainders pile up to n or more
    assign racc_sum = r_racc + r_wr;
    assign carry    = racc_sum >= n;
    assign n_racc   = carry ? (racc_sum - n) : racc_sum;
    assign n_bound  = r_bound + $signed(r_wq) + $signed({{(skwh_pkg::KEY_W-1){1'b0}}, carry});

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_key  <= '0;
            r_max_key  <= '0;
            r_num_bins <= skwh_pkg::NUM_BINS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                skwh_pkg::CFG_MIN_KEY:  r_min_key  <= i_cfg_data;
                skwh_pkg::CFG_MAX_KEY:  r_max_key  <= i_cfg_data;
                skwh_pkg::CFG_NUM_BINS: r_num_bins <= i_cfg_data[skwh_pkg::NBIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started   <= 1'b0;
            r_cur       <= '0;
            r_sum       <= '0;
            r_racc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.init_batch) begin
                r_started <= 1'b1;
                r_cur     <= '0;
                r_sum     <= '0;
                r_racc    <= div_r;
            end else if (i_cmd.emit) begin
                r_cur  <= cur_inc[skwh_pkg::NBIN_W-1:0];
                r_sum  <= '0;
                r_racc <= n_racc;
            end else if (i_cmd.accum) begin
                if (key_above_min && cur_lt_n) begin
                    r_sum <= r_sum + r_pt.point_value;
                end
            end else if (i_cmd.finish) begin
                r_started <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pt <= i_in_word;
        end
        if (i_cmd.init_batch) begin
            r_wq    <= div_q;
            r_wr    <= div_r;
            r_bound <= r_min_key + $signed(div_q);
        end else if (i_cmd.emit) begin
            r_bound <= n_bound;
        end
        if (i_cmd.emit) begin
            r_out.bin_number <= r_cur[skwh_pkg::BIN_W-1:0];
            r_out.bin_total  <= r_sum;
            r_out.final_bin  <= cur_inc == {1'b0, n};
        end
    end

    always_comb begin
        o_stat.started    = r_started;
        o_stat.div_done   = div_done;
        o_stat.key_emit   = cur_lt_n && key_above_min && (r_pt.point_key > open_bound);
        o_stat.flush_emit = cur_lt_n;
        o_stat.last       = r_pt.final_point;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

### rtl/skwh_ctrl.sv
// Controller state machine: accept, batch start division, bin scan, flush.
// Depends on skwh_pkg.
module skwh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  skwh_pkg::t_stat   i_stat,
    output logic              o_in_stall,
    output skwh_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;
    logic   n_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_stat.started) begin
                        n_state = S_SCAN;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.init_batch = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.key_emit) begin
                    o_cmd.emit = i_stat.out_free;
                end else begin
                    o_cmd.accum = 1'b1;
                    n_state     = i_stat.last ? S_FLUSH : S_IDLE;
                end
            end
            S_FLUSH: begin
                if (i_stat.flush_emit) begin
                    o_cmd.emit = i_stat.out_free;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_in_stall = n_state != S_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= n_in_stall;
        end
    end

    // stall mirrors the state, so in IDLE a valid word is always taken
    assign o_in_stall = r_in_stall;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for sorted_key_weighted_histogram_top: directed and random point batches.
// Depends on skwh_pkg and the histogram RTL only.
module tb_top;

    localparam int unsigned KEY_W        = skwh_pkg::KEY_W;
    localparam int unsigned NBIN_W       = skwh_pkg::NBIN_W;
    localparam int unsigned BIN_W        = skwh_pkg::BIN_W;
    localparam int unsigned CFG_IDX_W    = skwh_pkg::CFG_IDX_W;
    localparam int unsigned DEF_MAX_BINS = skwh_pkg::DEF_MAX_BINS;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
    // covers the division, a full flush of bins, plus margin
    localparam int DRAIN_CYCLES = 200;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [KEY_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    skwh_pkg::t_point     i_in_word   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    skwh_pkg::t_bin       o_out_word;

    logic calm = 1'b0;  // no idling on either side while set

    int err_count   = 0;
    int n_points    = 0;
    int n_bins_seen = 0;
    int n_writes    = 0;

    // register copies
    logic signed [KEY_W-1:0] reg_min_key  = '0;
    logic signed [KEY_W-1:0] reg_max_key  = '0;
    logic [NBIN_W-1:0]       reg_num_bins = skwh_pkg::NUM_BINS_RESET;

    // histogram state copy
    logic [NBIN_W-1:0] cur_bin    = '0;
    logic [KEY_W-1:0]  acc_sum    = '0;
    logic [KEY_W-1:0]  bound_hi   = '0;
    logic [KEY_W-1:0]  step_q     = '0;
    logic [NBIN_W-1:0] step_r     = '0;
    logic [NBIN_W-1:0] rem_acc    = '0;
    logic              batch_open = 1'b0;

    skwh_pkg::t_bin pending_bins [$];
    skwh_pkg::t_bin want;

    sorted_key_weighted_histogram_top #(
        .MAX_BINS (DEF_MAX_BINS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // key + d, clamped at the top of the signed key range
    function automatic logic signed [KEY_W-1:0] sat_add(input logic signed [KEY_W-1:0] k,
                                                        input logic [KEY_W-1:0] d);
        logic [KEY_W:0] s;
        s = {k[KEY_W-1], k} + {1'b0, d};
        if (s[KEY_W] != s[KEY_W-1])
            return KEY_MAX;
        return s[KEY_W-1:0];
    endfunction

    function automatic skwh_pkg::t_point mk_point(input logic signed [KEY_W-1:0] k,
                                                  input logic signed [KEY_W-1:0] v,
                                                  input logic fin);
        skwh_pkg::t_point p;
        p.point_key   = k;
        p.point_value = v;
        p.final_point = fin;
        return p;
    endfunction

    // exact integer stepping of the bin upper bound
    function automatic void advance_bound(input logic [NBIN_W-1:0] n);
        bound_hi = bound_hi + step_q;
        rem_acc  = rem_acc + step_r;
        if (rem_acc >= n) begin
            rem_acc  = rem_acc - n;
            bound_hi = bound_hi + 1;
        end
    endfunction

    function automatic void close_bin(input logic [NBIN_W-1:0] n);
        skwh_pkg::t_bin b;
        b.bin_number = cur_bin[BIN_W-1:0];
        b.bin_total  = acc_sum;
        b.final_bin  = (cur_bin + 1 == n);
        pending_bins.push_back(b);
        acc_sum = '0;
        cur_bin = cur_bin + 1'b1;
        advance_bound(n);
    endfunction

    // one accepted point: update the histogram copy, queue every bin it closes
    function automatic void histogram_step(input skwh_pkg::t_point p);
        logic [NBIN_W-1:0] n;
        logic [KEY_W-1:0]  span;
        n = reg_num_bins;
        if (n == 0)
            n = 1;
        if (n > DEF_MAX_BINS)
            n = DEF_MAX_BINS;
        if (!batch_open) begin
            span     = (reg_max_key > reg_min_key) ? reg_max_key - reg_min_key : '0;
            step_q   = span / n;
            step_r   = NBIN_W'(span % n);
            cur_bin  = '0;
            acc_sum  = '0;
            rem_acc  = '0;
            bound_hi = reg_min_key;
            advance_bound(n);
            batch_open = 1'b1;
        end
        if (p.point_key > reg_min_key) begin
            // last bin always ends at max_key, read live
            while (cur_bin < n &&
                   p.point_key > $signed((cur_bin + 1 >= n) ? reg_max_key : bound_hi))
                close_bin(n);
            if (cur_bin < n)
                acc_sum = acc_sum + p.point_value;
        end
        if (p.final_point) begin
            while (cur_bin < n)
                close_bin(n);
            batch_open = 1'b0;
        end
    endfunction

    // valid stays high across back-to-back words; it only drops on an idle cycle
    task automatic send_point(input skwh_pkg::t_point p);
        while (!calm && $urandom_range(0, 99) < 38) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= p;
        do @(posedge i_clk); while (o_in_stall);
        histogram_step(p);
        n_points++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_bins.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // drain, then write the selected registers back to back
    task automatic write_regs(input bit wr_min, input bit wr_max, input bit wr_bins,
                              input logic [KEY_W-1:0] min_v, input logic [KEY_W-1:0] max_v,
                              input logic [KEY_W-1:0] bins_v);
        logic [CFG_IDX_W-1:0] idx [3];
        logic [KEY_W-1:0]     val [3];
        bit                   sel [3];
        idx = '{skwh_pkg::CFG_MIN_KEY, skwh_pkg::CFG_MAX_KEY, skwh_pkg::CFG_NUM_BINS};
        val = '{min_v, max_v, bins_v};
        sel = '{wr_min, wr_max, wr_bins};
        wait_idle();
        for (int i = 0; i < 3; i++) begin
            if (sel[i]) begin
                i_cfg_we    <= 1'b1;
                i_cfg_index <= idx[i];
                i_cfg_data  <= val[i];
                @(posedge i_clk);
                case (idx[i])
                    skwh_pkg::CFG_MIN_KEY:  reg_min_key  = val[i];
                    skwh_pkg::CFG_MAX_KEY:  reg_max_key  = val[i];
                    skwh_pkg::CFG_NUM_BINS: reg_num_bins = val[i][NBIN_W-1:0];
                    default: ;
                endcase
                n_writes++;
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // reset config: empty span, 64 bins; skipped keys, then one key past everything
    task automatic test_reset_defaults();
        send_point(mk_point(-3, 7, 1'b0));
        send_point(mk_point(0, 9, 1'b0));
        send_point(mk_point(1, KEY_MAX, 1'b1));
    endtask

    // whole signed key range, a bin sum wrapping past the top
    task automatic test_full_key_span();
        write_regs(1, 1, 1, KEY_MIN, KEY_MAX, 64);
        send_point(mk_point(KEY_MIN, 5, 1'b0));
        send_point(mk_point(KEY_MIN + 1, KEY_MAX, 1'b0));
        send_point(mk_point(KEY_MIN + 1, 1, 1'b0));
        send_point(mk_point(0, KEY_MIN, 1'b0));
        send_point(mk_point(KEY_MAX, -1, 1'b1));
    endtask

    // num_bins 0 acts as one bin, above 64 acts as 64
    task automatic test_bin_count_limits();
        write_regs(1, 1, 1, -100, 100, 0);
        send_point(mk_point(-50, 3, 1'b0));
        send_point(mk_point(100, 4, 1'b1));
        write_regs(1, 1, 1, 0, 63, 127);
        send_point(mk_point(10, 1, 1'b0));
        send_point(mk_point(200, 2, 1'b1));
    endtask

    // max below min, then max equal to min
    task automatic test_empty_range();
        write_regs(1, 1, 1, 50, -50, 4);
        send_point(mk_point(60, 5, 1'b1));
        write_regs(0, 1, 0, 0, 50, 0);
        send_point(mk_point(51, 1, 1'b0));
        send_point(mk_point(51, 2, 1'b1));
    endtask

    // a key that goes backward lands in the open bin
    task automatic test_out_of_order();
        write_regs(1, 1, 1, 0, 1000, 10);
        send_point(mk_point(500, 1, 1'b0));
        send_point(mk_point(200, 2, 1'b0));
        send_point(mk_point(950, 3, 1'b0));
        send_point(mk_point(10, 4, 1'b1));
    endtask

    // past max_key: all bins close, later values are dropped
    task automatic test_above_max();
        write_regs(1, 1, 1, 0, 99, 7);
        send_point(mk_point(40, 1, 1'b0));
        send_point(mk_point(150, 2, 1'b0));
        send_point(mk_point(160, 3, 1'b0));
        send_point(mk_point(20, 4, 1'b1));
    endtask

    // quotient stays latched; max_key and num_bins take effect at once
    task automatic test_write_mid_batch();
        write_regs(1, 1, 1, 0, 700, 7);
        send_point(mk_point(50, 1, 1'b0));
        write_regs(0, 1, 1, 0, 300, 5);
        send_point(mk_point(250, 2, 1'b0));
        send_point(mk_point(400, 3, 1'b1));
    endtask

    // batches of mostly ascending keys across random register settings
    task automatic test_random_batches(input int target);
        int                      sent;
        int                      len;
        logic signed [KEY_W-1:0] lo;
        logic signed [KEY_W-1:0] hi;
        logic signed [KEY_W-1:0] key;
        logic [KEY_W-1:0]        span;
        logic [KEY_W-1:0]        stp;
        logic [KEY_W-1:0]        nb;
        skwh_pkg::t_point        p;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 5))
                    0: begin
                        lo = 64'($urandom_range(0, 2000)) - 64'd1000;
                        hi = lo + $urandom_range(0, 3000);
                    end
                    1: begin
                        lo = KEY_MIN;
                        hi = KEY_MAX;
                    end
                    2: begin
                        lo = rand64();
                        hi = rand64();
                    end
                    3: begin
                        lo = 64'($urandom_range(0, 2000)) - 64'd1000;
                        hi = lo - $urandom_range(0, 5);
                    end
                    4: begin
                        lo = rand64();
                        hi = sat_add(lo, rand64() & 64'hFF_FFFF_FFFF);
                    end
                    default: begin
                        lo = 64'($urandom_range(0, 2000)) - 64'd1000;
                        hi = lo + $urandom_range(0, 70);
                    end
                endcase
                // upper data bits are random; only the low 7 count
                nb = rand64();
                case ($urandom_range(0, 9))
                    0: nb[NBIN_W-1:0] = '0;
                    1: nb[NBIN_W-1:0] = NBIN_W'($urandom_range(65, 127));
                    2: nb[NBIN_W-1:0] = NBIN_W'(DEF_MAX_BINS);
                    3: nb[NBIN_W-1:0] = NBIN_W'(1);
                    default: nb[NBIN_W-1:0] = NBIN_W'($urandom_range(1, 64));
                endcase
                write_regs(1, 1, 1, lo, hi, nb);
            end
            len  = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            calm <= (sent >= 120 && sent < 200);
            span = (reg_max_key > reg_min_key) ? reg_max_key - reg_min_key : 64'd64;
            stp  = span / len;
            if (stp == 0)
                stp = 1;
            key = (reg_min_key > KEY_MIN + 16) ? reg_min_key - $urandom_range(0, 16)
                                               : reg_min_key;
            for (int i = 0; i < len; i++) begin
                key = sat_add(sat_add(key, rand64() % stp), rand64() % stp);
                // one in ten keys lands anywhere
                p.point_key = ($urandom_range(0, 9) == 0) ? rand64() : key;
                case ($urandom_range(0, 3))
                    1: p.point_value = 64'($urandom_range(0, 200)) - 64'd100;
                    2: p.point_value = ($urandom_range(0, 1) == 0) ? KEY_MAX :
                                       ($urandom_range(0, 1) == 0) ? KEY_MIN : -64'sd1;
                    default: p.point_value = rand64();
                endcase
                p.final_point = (i == len - 1);
                send_point(p);
                sent++;
                if (len >= 3 && i == len / 2 && $urandom_range(0, 9) == 0)
                    write_regs(0, 1, 1, 0, sat_add(reg_min_key, rand64() % span),
                               64'($urandom_range(1, 64)));
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 38);
    end

    // compare each accepted bin word with the oldest queued one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_bins_seen++;
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected bin word, expected none, got %h", $time, o_out_word);
                err_count++;
            end else begin
                want = pending_bins.pop_front();
                if (o_out_word.bin_number !== want.bin_number) begin
                    $display("%0t: bin_number expected %0d got %0d",
                             $time, want.bin_number, o_out_word.bin_number);
                    err_count++;
                end
                if (o_out_word.bin_total !== want.bin_total) begin
                    $display("%0t: bin_total expected %0d got %0d",
                             $time, want.bin_total, o_out_word.bin_total);
                    err_count++;
                end
                if (o_out_word.final_bin !== want.final_bin) begin
                    $display("%0t: final_bin expected %0b got %0b",
                             $time, want.final_bin, o_out_word.final_bin);
                    err_count++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (5) @(posedge i_clk);
        test_reset_defaults();
        test_full_key_span();
        test_bin_count_limits();
        test_empty_range();
        test_out_of_order();
        test_above_max();
        test_write_mid_batch();
        test_random_batches(345);
        calm <= 1'b0;
        wait_idle();
        $display("Sent %0d points, checked %0d bin words, made %0d register writes.",
                 n_points, n_bins_seen, n_writes);
        $display("Bin counts 0..127, spans full, random, narrow and empty, random back pressure.");
        if (err_count == 0 && pending_bins.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### sorted_key_weighted_histogram_top.f
rtl/skwh_pkg.sv
rtl/skwh_div.sv
rtl/skwh_dp.sv
rtl/skwh_ctrl.sv
rtl/sorted_key_weighted_histogram_top.sv
tb/tb_top.sv
